FILE: rtl/lru_pr_pkg.sv
// package: types and constants shared by the lru page replacement files
`default_nettype none

package lru_pr_pkg;

  localparam int CfgW         = 5;
  localparam int PageW        = 16;
  localparam int CountW       = 16;
  localparam int MaxFramesDef = 16;

  localparam logic [CfgW-1:0]   CfgReset = CfgW'(4);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef logic [CfgW-1:0]   cfg_t;
  typedef logic [PageW-1:0]  page_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic  valid;
    page_t page;
  } frame_t;

  typedef struct packed {
    logic  upd;
    logic  clr;
    logic  miss;
    page_t page;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/lru_req_if.sv
// interface: page reference channel
`default_nettype none

interface lru_req_if;
  import lru_pr_pkg::*;

  logic  valid;
  logic  ready;
  page_t page;
  logic  end_of_string;

  modport source (output valid, output page, output end_of_string, input ready);
  modport sink   (input valid, input page, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/lru_rsp_if.sv
// interface: fault result channel
`default_nettype none

interface lru_rsp_if;
  import lru_pr_pkg::*;

  logic   valid;
  logic   ready;
  logic   fault;
  count_t fault_count;

  modport source (output valid, output fault, output fault_count, input ready);
  modport sink   (input valid, input fault, input fault_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/lru_pr_cell.sv
// one frame cell of the lru stack: compare, hit chain and shift from neighbor
`default_nettype none

module lru_pr_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lru_pr_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                   active_i,
  input  wire logic                   top_i,
  input  wire logic                   hit_prior_i,
  output logic                        hit_prior_o,
  input  wire lru_pr_pkg::frame_t     next_i,
  output lru_pr_pkg::frame_t          frame_o,
  output logic                        match_o
);
  import lru_pr_pkg::*;

  logic  valid_q, valid_d;
  page_t page_q, page_d;
  logic  shift;

  assign match_o     = active_i & valid_q & (page_q == ctrl_i.page);
  assign hit_prior_o = hit_prior_i | match_o;
  assign shift       = active_i & (ctrl_i.miss | hit_prior_o);

  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    if (ctrl_i.upd) begin
      if (active_i && top_i) begin
        valid_d = 1'b1;
        page_d  = ctrl_i.page;
      end else if (shift) begin
        valid_d = next_i.valid;
        page_d  = next_i.page;
      end
    end
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign frame_o = '{valid: valid_q, page: page_q};

endmodule

`default_nettype wire

FILE: rtl/lru_page_replacement_unit.sv
// top level: lru page replacement stack built from a row of frame cells
// results: each result is registered in the output register when its item is accepted
// throughput: one item per cycle while the result channel is ready; the compare, hit chain and
//   shift across the cell row all complete in the cycle of acceptance
// reset: all frames empty, fault count zero, frame count configuration 4
// a configuration write or an accepted end-of-string item also empties the stack
`default_nettype none

module lru_page_replacement_unit #(
  parameter int MAX_FRAMES = lru_pr_pkg::MaxFramesDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [lru_pr_pkg::CfgW-1:0] cfg_wdata_i,
  lru_req_if.sink                    req_i,
  lru_rsp_if.source                  rsp_o
);
  import lru_pr_pkg::*;

  localparam int FrW = $clog2(MAX_FRAMES + 1);
  localparam int NW  = (FrW > CfgW) ? FrW : CfgW;

  cfg_t          cfg_q;
  logic [NW-1:0] cfg_ext, n_eff, top_idx;
  count_t        cnt_q, cnt_d;
  logic          out_valid_q;
  logic          fault_q;
  count_t        fault_count_q;
  logic          acc, miss;
  cell_ctrl_t    ctrl;

  logic   hit_chain [MAX_FRAMES+1];
  frame_t frames    [MAX_FRAMES];
  frame_t nexts     [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] valid_vec;

  assign cfg_ext = NW'(cfg_q);

  always_comb begin
    if (cfg_ext == '0) begin
      n_eff = NW'(1);
    end else if (cfg_ext > NW'(MAX_FRAMES)) begin
      n_eff = NW'(MAX_FRAMES);
    end else begin
      n_eff = cfg_ext;
    end
  end

  assign top_idx = n_eff - NW'(1);

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign miss        = !hit_chain[MAX_FRAMES];

  assign ctrl = '{upd:  acc,
                  clr:  cfg_we_i || (acc && req_i.end_of_string),
                  miss: miss,
                  page: req_i.page};

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    if (i == MAX_FRAMES - 1) begin : g_last
      assign nexts[i] = '0;
    end else begin : g_mid
      assign nexts[i] = frames[i+1];
    end

    lru_pr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .active_i    (NW'(i) < n_eff),
      .top_i       (NW'(i) == top_idx),
      .hit_prior_i (hit_chain[i]),
      .hit_prior_o (hit_chain[i+1]),
      .next_i      (nexts[i]),
      .frame_o     (frames[i]),
      .match_o     (match_vec[i])
    );

    assign valid_vec[i] = frames[i].valid;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (miss && (cnt_q != CountMax)) begin
      cnt_d = cnt_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cfg_we_i || (acc && req_i.end_of_string)) begin
        cnt_q <= '0;
      end else if (acc) begin
        cnt_q <= cnt_d;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      fault_q       <= miss;
      fault_count_q <= cnt_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.fault       = fault_q;
  assign rsp_o.fault_count = fault_count_q;

`ifndef SYNTHESIS
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("more than one frame matches the page");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_i.end_of_string |=> (valid_vec == '0) && (cnt_q == '0))
    else $error("stack not cleared after end of string");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !req_i.end_of_string && !cfg_we_i |=>
      rsp_o.valid && (rsp_o.fault_count == cnt_q))
    else $error("result count does not match running count");

  a_miss_incr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && miss && (cnt_q != CountMax) |-> cnt_d == cnt_q + CountW'(1))
    else $error("fault count not advanced on a miss");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_lru_page_replacement_unit.sv
`timescale 1ns / 100ps
// testbench: lru page replacement unit checked against a behavioral lru stack
module tb_lru_page_replacement_unit;
  import lru_pr_pkg::*;

  localparam int NumFrames  = MaxFramesDef;
  localparam int IdlePct    = 6;
  localparam int StallLimit = 1000;
  localparam int RandPhases = 12;
  localparam int PhaseRefs  = 120;

  typedef struct packed {
    page_t page;
    logic  eos;
  } page_ref_t;

  typedef struct packed {
    logic   fault;
    count_t count;
  } fault_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  cfg_t cfg_wdata;

  lru_req_if req_if ();
  lru_rsp_if rsp_if ();

  lru_page_replacement_unit #(
    .MAX_FRAMES(NumFrames)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  page_ref_t  ref_pending_q[$];
  fault_res_t fault_expect_q[$];
  int         err_cnt = 0;
  int         cyc_cnt = 0;
  int         quiet_cnt = 0;
  int         pushed_cnt = 0;
  int         taken_cnt = 0;
  logic       req_fire = 1'b0;

  cfg_t   stack_cfg;
  page_t  stack_page[NumFrames];
  logic   stack_valid[NumFrames];
  count_t stack_misses;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void stack_clear();
    for (int k = 0; k < NumFrames; k++) begin
      stack_page[k]  = '0;
      stack_valid[k] = 1'b0;
    end
    stack_misses = '0;
  endfunction

  function automatic int frames_used(cfg_t v);
    if (v == 0) return 1;
    if (v > NumFrames) return NumFrames;
    return int'(v);
  endfunction

  function automatic fault_res_t stack_lookup(page_ref_t item);
    int         n;
    int         pos;
    logic       hit;
    fault_res_t res;
    n   = frames_used(stack_cfg);
    hit = 1'b0;
    pos = 0;
    for (int k = 0; k < n; k++) begin
      if (!hit && stack_valid[k] && stack_page[k] == item.page) begin
        hit = 1'b1;
        pos = k;
      end
    end
    if (!hit && stack_misses != CountMax) stack_misses++;
    // close up behind the removed entry, front entry on a miss
    for (int k = pos; k < n - 1; k++) begin
      stack_page[k]  = stack_page[k+1];
      stack_valid[k] = stack_valid[k+1];
    end
    stack_page[n-1]  = item.page;
    stack_valid[n-1] = 1'b1;
    res.fault = !hit;
    res.count = stack_misses;
    if (item.eos) stack_clear();
    return res;
  endfunction

  // monitor and checker
  always @(posedge clk_i) begin : monitor
    fault_res_t got;
    fault_res_t want;
    page_ref_t  item;
    logic       rsp_fire;
    cyc_cnt++;
    req_fire = rst_ni && req_if.valid && req_if.ready;
    rsp_fire = rst_ni && rsp_if.valid && rsp_if.ready;
    if (!rst_ni) begin
      stack_cfg = CfgReset;
      stack_clear();
      fault_expect_q.delete();
      quiet_cnt = 0;
    end else begin
      if (cfg_we) begin
        stack_cfg = cfg_wdata;
        stack_clear();
      end
      if (rsp_fire) begin
        got.fault = rsp_if.fault;
        got.count = rsp_if.fault_count;
        if (fault_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual fault %0b count %0d",
                   $time, got.fault, got.count);
        end else begin
          want = fault_expect_q.pop_front();
          if (got.fault !== want.fault) begin
            err_cnt++;
            $display("%0t: fault mismatch, expected %0b, actual %0b",
                     $time, want.fault, got.fault);
          end
          if (got.count !== want.count) begin
            err_cnt++;
            $display("%0t: fault_count mismatch, expected %0d, actual %0d",
                     $time, want.count, got.count);
          end
        end
      end
      if (req_fire) begin
        item.page = req_if.page;
        item.eos  = req_if.end_of_string;
        fault_expect_q.push_back(stack_lookup(item));
        taken_cnt++;
      end
      if (req_fire || rsp_fire) begin
        quiet_cnt = 0;
      end else if (++quiet_cnt >= StallLimit) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // driver for the reference channel and the result ready
  always @(negedge clk_i) begin : driver
    page_ref_t item;
    logic      calm;
    calm = (cyc_cnt % 3000) < 700;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= calm || ($urandom_range(99) >= IdlePct);
      if (!req_if.valid || req_fire) begin
        if (ref_pending_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          item = ref_pending_q.pop_front();
          req_if.valid         <= 1'b1;
          req_if.page          <= item.page;
          req_if.end_of_string <= item.eos;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic add_ref(page_t pg, logic eos);
    page_ref_t item;
    item.page = pg;
    item.eos  = eos;
    ref_pending_q.push_back(item);
    pushed_cnt++;
  endtask

  task automatic drain();
    do @(negedge clk_i); while (taken_cnt != pushed_cnt || fault_expect_q.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_frames(cfg_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    cfg_t  v;
    cfg_t  cfg_list[7];
    int    pool;
    page_t base;
    page_t pg;
    cfg_list = '{5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'd0, 5'd8};
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_if.valid         = 1'b0;
    req_if.page          = '0;
    req_if.end_of_string = 1'b0;
    rsp_if.ready         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size of four, page zero never matches an empty frame
    add_ref(16'h0000, 1'b0);
    add_ref(16'h0000, 1'b0);
    add_ref(16'hFFFF, 1'b0);
    add_ref(16'h0001, 1'b0);
    add_ref(16'h0002, 1'b0);
    add_ref(16'h0000, 1'b0);
    add_ref(16'h0003, 1'b0);
    add_ref(16'hFFFF, 1'b0);
    add_ref(16'h0002, 1'b0);
    add_ref(16'h0000, 1'b0);
    add_ref(16'h5555, 1'b0);
    add_ref(16'hAAAA, 1'b1);

    // size zero acts as one frame
    write_frames(5'd0);
    add_ref(16'h0007, 1'b0);
    add_ref(16'h0007, 1'b0);
    add_ref(16'h0008, 1'b0);
    add_ref(16'h0007, 1'b1);

    // random strings over several stack sizes
    for (int p = 0; p < RandPhases; p++) begin
      v = (p < 7) ? cfg_list[p] : cfg_t'($urandom_range(31));
      write_frames(v);
      pool = $urandom_range(frames_used(v) + 4, 1);
      base = page_t'($urandom());
      for (int i = 0; i < PhaseRefs; i++) begin
        if ($urandom_range(99) < 85) pg = base + page_t'($urandom_range(pool - 1));
        else pg = page_t'($urandom());
        add_ref(pg, $urandom_range(29) == 0);
      end
    end

    drain();
    repeat (5) @(negedge clk_i);
    if (fault_expect_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, fault_expect_q.size());
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lru_pr_pkg.sv
rtl/lru_req_if.sv
rtl/lru_rsp_if.sv
rtl/lru_pr_cell.sv
rtl/lru_page_replacement_unit.sv
dv/tb_lru_page_replacement_unit.sv
